>>> sv/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and constants for the multi-queue shared buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

    localparam int ENTRIES = 16;
    localparam int QUEUES  = 4;

    localparam int IDX_W    = $clog2(ENTRIES + 1);
    localparam int ENT_AW   = $clog2(ENTRIES);
    localparam int QID_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [IDX_W-1:0] NIL_LINK = IDX_W'(ENTRIES);

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // link value of an entry that was never written since reset
    function automatic logic [IDX_W-1:0] link_reset_val(input logic [ENT_AW-1:0] addr);
        logic [IDX_W-1:0] nxt;
        nxt = IDX_W'(addr) + IDX_W'(1);
        return nxt;
    endfunction

    function automatic logic slot_valid(input logic [IDX_W-1:0] idx);
        return idx < NIL_LINK;
    endfunction

endpackage

`default_nettype wire

>>> sv/multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Several FIFO queues kept as linked lists in one shared entry memory,
// with unused entries chained on a free list.
// ----------------------------------------------------------------------------
// Flow: a request is read from the link and entry memories on transfer and
// written back in the exec state, where its result is registered; in_stall
//   holds off a new request while in exec or while out_stall holds a result.
// Reset: all queues empty, free list 0..ENTRIES-1 in order; link memory
//   reset values come from per-entry written bits, so there is no clearing pass.
`default_nettype none

module multi_queue_shared_buffer
    import mqsb_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic                        func,
    input  wire logic [QID_W-1:0]            queue_id,
    input  wire logic signed [DATA_W-1:0]    data_in,

    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic signed [DATA_W-1:0]    data_out,
    output      logic [STATUS_W-1:0]         status
);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg [QUEUES];
    logic [IDX_W-1:0] head_next [QUEUES];
    logic [IDX_W-1:0] tail_reg [QUEUES];
    logic [IDX_W-1:0] tail_next [QUEUES];
    logic [IDX_W-1:0] free_head_reg, free_head_next;

    logic [IDX_W-1:0] link_mem [ENTRIES];
    logic [DATA_W-1:0] entry_mem [ENTRIES];
    logic [ENTRIES-1:0] link_wr_reg;

    logic                     func_reg;
    logic [QID_W-1:0]         q_reg;
    logic                     q_ok_reg;
    logic [DATA_W-1:0]        data_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic [IDX_W-1:0]         link_mem_rd_reg;
    logic                     link_wr_rd_reg;
    logic [DATA_W-1:0]        entry_rd_reg;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] data_out_reg, data_out_next;
    logic [STATUS_W-1:0]      status_reg, status_next;

    logic                     in_xfer;
    logic [IDX_W-1:0]         rd_slot;
    logic [ENT_AW-1:0]        rd_addr;
    logic                     q_ok;
    logic [IDX_W-1:0]         link_rd;

    logic                     link_we;
    logic [ENT_AW-1:0]        link_waddr;
    logic [IDX_W-1:0]         link_wdata;
    logic                     entry_we;

    assign in_stall  = (state_reg == ST_EXEC) || (out_valid_reg && out_stall);
    assign in_xfer   = in_valid && !in_stall;
    assign q_ok      = int'(queue_id) < QUEUES;
    assign rd_slot   = (func == FUNC_DEQ) ? head_reg[queue_id] : free_head_reg;
    assign rd_addr   = rd_slot[ENT_AW-1:0];
    assign link_rd   = link_wr_rd_reg ? link_mem_rd_reg
                                      : link_reset_val(slot_reg[ENT_AW-1:0]);

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        out_valid_next = out_valid_reg && out_stall;
        data_out_next  = data_out_reg;
        status_next    = status_reg;
        link_we        = 1'b0;
        link_waddr     = slot_reg[ENT_AW-1:0];
        link_wdata     = free_head_reg;
        entry_we       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                data_out_next  = '0;
                if (func_reg == FUNC_ENQ)
                begin
                    if (!q_ok_reg || !slot_valid(slot_reg))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next    = STATUS_OK;
                        free_head_next = link_rd;
                        entry_we       = 1'b1;
                        if (!slot_valid(head_reg[q_reg]))
                        begin
                            head_next[q_reg] = slot_reg;
                        end
                        else if (slot_valid(tail_reg[q_reg]))
                        begin
                            link_we    = 1'b1;
                            link_waddr = tail_reg[q_reg][ENT_AW-1:0];
                            link_wdata = slot_reg;
                        end
                        tail_next[q_reg] = slot_reg;
                    end
                end
                else
                begin
                    if (!q_ok_reg || !slot_valid(slot_reg))
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        // tail link is stale; the tail entry always ends the list
                        status_next    = STATUS_OK;
                        data_out_next  = entry_rd_reg;
                        free_head_next = slot_reg;
                        link_we        = 1'b1;
                        link_wdata     = free_head_reg;
                        if (slot_reg == tail_reg[q_reg] || !slot_valid(link_rd))
                        begin
                            head_next[q_reg] = NIL_LINK;
                        end
                        else
                        begin
                            head_next[q_reg] = link_rd;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_head_reg  <= '0;
            out_valid_reg  <= 1'b0;
            link_wr_reg    <= '0;
            link_wr_rd_reg <= 1'b0;
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= NIL_LINK;
                tail_reg[i] <= NIL_LINK;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            if (link_we)
            begin
                link_wr_reg[link_waddr] <= 1'b1;
            end
            if (in_xfer)
            begin
                link_wr_rd_reg <= link_wr_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg <= data_out_next;
        status_reg   <= status_next;
        if (in_xfer)
        begin
            func_reg <= func;
            q_reg    <= queue_id;
            q_ok_reg <= q_ok;
            data_reg <= data_in;
            slot_reg <= rd_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            link_mem_rd_reg <= link_mem[rd_addr];
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            entry_rd_reg <= entry_mem[rd_addr];
        end
        if (entry_we)
        begin
            entry_mem[slot_reg[ENT_AW-1:0]] <= data_reg;
        end
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> ##2 out_valid)
        else $error("no result two cycles after input transfer");

    a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NIL_LINK)
        else $error("free list head out of range");

    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |-> data_out == '0)
        else $error("nonzero data on error result");

    a_enq_pops_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && func_reg == FUNC_ENQ && q_ok_reg
         && slot_valid(slot_reg)) |=> free_head_reg != $past(free_head_reg))
        else $error("enqueue did not advance free list");

endmodule

`default_nettype wire

>>> tb/tb_multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// tb_multi_queue_shared_buffer
// Self-checking bench for the linked-list multi-queue buffer. A scoreboard
// tracks its own copy of the queue heads, tails, link memory and free list,
// predicts status and word for every accepted request, and compares each
// result transfer in order. Directed requests cover empty, full, emptied
// queues and extreme words. Random phases then shift the enqueue/dequeue
// mix and queue focus, with random idle bursts on both sides and one long
// output hold.
// ----------------------------------------------------------------------------
module tb_multi_queue_shared_buffer
    import mqsb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 150;

    typedef struct {
        logic signed [DATA_W-1:0] word;
        logic [STATUS_W-1:0]      code;
    } queue_result_t;

    class mqsb_scoreboard;
        logic [IDX_W-1:0]         q_head [QUEUES];
        logic [IDX_W-1:0]         q_tail [QUEUES];
        logic [IDX_W-1:0]         next_link [ENTRIES];
        logic signed [DATA_W-1:0] word_mem [ENTRIES];
        logic [IDX_W-1:0]         free_top;
        queue_result_t            pending_results [$];
        int                       errors;

        function new();
            for (int i = 0; i < QUEUES; i++)
            begin
                q_head[i] = NIL_LINK;
                q_tail[i] = NIL_LINK;
            end
            for (int i = 0; i < ENTRIES; i++)
            begin
                next_link[i] = IDX_W'(i + 1);
                word_mem[i]  = '0;
            end
            next_link[ENTRIES-1] = NIL_LINK;
            free_top = '0;
            errors = 0;
        endfunction

        function bit in_store(logic [IDX_W-1:0] idx);
            return int'(idx) < ENTRIES;
        endfunction

        function void note_request(logic f, logic [QID_W-1:0] q,
                                   logic signed [DATA_W-1:0] d);
            queue_result_t    r;
            logic [IDX_W-1:0] slot;
            r.word = '0;
            r.code = STATUS_OK;
            if (int'(q) >= QUEUES)
            begin
                r.code = (f == FUNC_DEQ) ? STATUS_EMPTY : STATUS_FULL;
            end
            else if (f == FUNC_ENQ)
            begin
                slot = free_top;
                if (!in_store(slot))
                begin
                    r.code = STATUS_FULL;
                end
                else
                begin
                    free_top = next_link[slot];
                    if (!in_store(q_head[q]))
                        q_head[q] = slot;
                    else if (in_store(q_tail[q]))
                        next_link[q_tail[q]] = slot;
                    next_link[slot] = NIL_LINK;
                    q_tail[q] = slot;
                    word_mem[slot] = d;
                end
            end
            else
            begin
                slot = q_head[q];
                if (!in_store(slot))
                begin
                    r.code = STATUS_EMPTY;
                end
                else
                begin
                    q_head[q] = in_store(next_link[slot]) ? next_link[slot] : NIL_LINK;
                    next_link[slot] = free_top;
                    free_top = slot;
                    r.word = word_mem[slot];
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic signed [DATA_W-1:0] word,
                                   logic [STATUS_W-1:0] code);
            queue_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: data_out %0d, status %0d", word, code);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (code !== exp_r.code)
            begin
                $error("status mismatch: expected %0d, got %0d", exp_r.code, code);
                errors++;
            end
            if (word !== exp_r.word)
            begin
                $error("data_out mismatch: expected %0d, got %0d", exp_r.word, word);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     func;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] data_in;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] data_out;
    logic [STATUS_W-1:0]      status;

    mqsb_scoreboard sb;
    bit             idle_on;
    bit             hold_request;
    int             cycle_count = 0;

    multi_queue_shared_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .queue_id  (queue_id),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .status    (status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_multi_queue_shared_buffer failed");
            $finish;
        end
    end

    task automatic send_request(logic f, logic [QID_W-1:0] q, logic signed [DATA_W-1:0] d);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        queue_id <= q;
        data_in  <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(f, q, d);
    endtask

    // result side: random stall bursts, plus one long hold on request
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(data_out, status);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            out_stall <= (stall_left > 0) || (hold_left > 0);
            if (stall_left > 0)
                stall_left--;
            if (hold_left > 0)
                hold_left--;
        end
    end

    initial
    begin : stimulus
        logic [DATA_W-1:0] patterns [7];
        int                enq_pct;
        int                focus_q;
        logic              f;
        logic [QID_W-1:0]  q;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_ENQ;
        queue_id     = '0;
        data_in      = '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        sb = new();
        patterns = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queues, fill the store, overflow, drain one queue past empty
        send_request(FUNC_DEQ, QID_W'(0), $urandom());
        send_request(FUNC_DEQ, QID_W'(3), $urandom());
        for (int i = 0; i < ENTRIES; i++)
            send_request(FUNC_ENQ, QID_W'(i % QUEUES), (i < 7) ? patterns[i] : $urandom());
        send_request(FUNC_ENQ, QID_W'(1), $urandom());
        for (int i = 0; i < 5; i++)
            send_request(FUNC_DEQ, QID_W'(0), $urandom());
        send_request(FUNC_ENQ, QID_W'(0), 32'h8000_0001);
        send_request(FUNC_DEQ, QID_W'(0), $urandom());

        enq_pct = 50;
        focus_q = -1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: enq_pct = 20;
                    1: enq_pct = 80;
                    2: enq_pct = 95;
                    default: enq_pct = 50;
                endcase
                focus_q = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, QUEUES - 1);
            end
            if (n % 100 == 0)
                idle_on = (n < RANDOM_ITEMS - 300) && ($urandom_range(0, 3) != 0);
            if (n == 600)
                hold_request = 1'b1;
            f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            if (focus_q >= 0 && $urandom_range(0, 9) < 7)
                q = QID_W'(focus_q);
            else
                q = QID_W'($urandom_range(0, QUEUES - 1));
            send_request(f, q, $urandom());
        end
        in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_multi_queue_shared_buffer passed");
        else
            $display("tb_multi_queue_shared_buffer failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/mqsb_pkg.sv
sv/multi_queue_shared_buffer.sv
tb/tb_multi_queue_shared_buffer.sv
